@@ src/fccw_pkg.sv @@
// Shared constants, register indexes and control/status structs of the
// FAT12 cluster chain walker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fccw_pkg;

    // table store geometry and chain limit
    localparam int TABLE_BYTES = 8192;
    localparam int TABLE_AW    = $clog2(TABLE_BYTES);
    localparam int MAX_CHAIN   = 64;
    localparam int CNT_W       = $clog2(MAX_CHAIN + 1);

    // field widths
    localparam int ADDR_W  = 13;
    localparam int BYTE_W  = 8;
    localparam int CLU_W   = 12;
    localparam int LBA_W   = 32;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 16;

    // root directory divide: 32 * root_entry_count / bytes_per_sector
    localparam int DVD_W = 21;
    localparam int DVS_W = 13;

    localparam logic [CLU_W-1:0] END_MARK = 12'hFF8;

    // configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_BYTES_PER_SECTOR    = 3'd0,
        CFG_SECTORS_PER_CLUSTER = 3'd1,
        CFG_RESERVED_SECTORS    = 3'd2,
        CFG_FAT_COUNT           = 3'd3,
        CFG_SECTORS_PER_FAT     = 3'd4,
        CFG_ROOT_ENTRY_COUNT    = 3'd5
    } t_cfg_idx;

    // controller -> datapath
    typedef struct packed {
        logic load;      // write table byte
        logic walk;      // latch start cluster, start root divide
        logic root_load; // form root directory end
        logic rd_lo;     // read low table byte, form product
        logic rd_hi;     // read high table byte, form lba
        logic nxt_load;  // decode next cluster
        logic emit;      // load output register
        logic step;      // advance to next cluster
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic req_walk;
        logic start_bad;
        logic div_done;
        logic out_free;
        logic last;
    } t_status;

endpackage

`default_nettype wire

@@ src/fat12_cluster_chain_walker_unit.sv @@
// Top level of the FAT12 cluster chain walker: controller plus datapath.
// Depends on fccw_pkg, fccw_ctrl, fccw_dpath (and fccw_div below it).
//
// Input channel (i_in_valid / o_in_stall): a word with req_type 0 writes one
// allocation table byte at table_addr and gives no result; the block stays idle.
// A word with req_type 1 walks the chain from start_cluster and gives one
// result word per cluster, the final one flagged last.
// Output channel (o_out_valid / i_out_stall): cluster, sector_lba, last,
// bad_start, truncated. The result sits in an output register, so the next
// input word is taken while the last result of a walk still waits.
// Walk: a start cluster below 2 skips the divide and goes straight to the
// output load for its single result. Otherwise the root directory size is
// divided out one bit a cycle, then each cluster takes two reads of the
// single-port table store, the next-link decode and the output load. A walk
// holds o_in_stall high throughout and covers at most 64 clusters. A stalled
// receiver holds the walk in place at its next result.
// Configuration (i_cfg_valid / o_cfg_ready) is always ready, index 0..5.
// Reset restores the default geometry and clears all control state; the
// table store holds no defined contents until loaded.
`timescale 1ns / 1ps
`default_nettype none

module fat12_cluster_chain_walker_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [fccw_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [fccw_pkg::CFG_DW-1:0]  i_cfg_data,
    // input channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_req_type,
    input  wire logic [fccw_pkg::ADDR_W-1:0]  i_table_addr,
    input  wire logic [fccw_pkg::BYTE_W-1:0]  i_table_byte,
    input  wire logic [fccw_pkg::CLU_W-1:0]   i_start_cluster,
    // output channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [fccw_pkg::CLU_W-1:0]        o_cluster,
    output logic [fccw_pkg::LBA_W-1:0]        o_sector_lba,
    output logic                              o_last,
    output logic                              o_bad_start,
    output logic                              o_truncated
);

    fccw_pkg::t_cmd    cmd;
    fccw_pkg::t_status status;
    logic              busy;
    logic              in_acc;

    fccw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    fccw_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_table_addr    (i_table_addr),
        .i_table_byte    (i_table_byte),
        .i_start_cluster (i_start_cluster),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_cluster       (o_cluster),
        .o_sector_lba    (o_sector_lba),
        .o_last          (o_last),
        .o_bad_start     (o_bad_start),
        .o_truncated     (o_truncated)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy;
    assign in_acc      = i_in_valid && !busy;

    // a walk always occupies the block for at least the next cycle
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_req_type |=> o_in_stall)
        else $error("walk accepted but block not busy");

    // after a table load the block is not busy in the next cycle
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_req_type |=> !o_in_stall)
        else $error("table load did not complete in one cycle");

    a_bad_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_start |->
            o_last && !o_truncated && (o_sector_lba == '0))
        else $error("bad start word malformed");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truncated |-> o_last)
        else $error("truncated word not marked last");

endmodule

`default_nettype wire

@@ src/fccw_div.sv @@
// Restoring divider, one quotient bit per cycle, for the root directory size.
// Depends on fccw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fccw_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [fccw_pkg::DVD_W-1:0]   i_dividend,
    input  wire logic [fccw_pkg::DVS_W-1:0]   i_divisor,
    output logic                              o_done,
    output logic [fccw_pkg::DVD_W-1:0]        o_quotient,
    output logic                              o_rem_nz
);

    localparam int STEP_W = $clog2(fccw_pkg::DVD_W + 1);

    logic [STEP_W-1:0]          r_cnt;
    logic                       r_done;
    logic [fccw_pkg::DVS_W-1:0] r_dvs;
    logic [fccw_pkg::DVS_W-1:0] r_rem;
    logic [fccw_pkg::DVD_W-1:0] r_quo;

    logic [fccw_pkg::DVS_W:0]   trial;
    logic                       fits;

    assign trial = {r_rem, r_quo[fccw_pkg::DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= STEP_W'(fccw_pkg::DVD_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? fccw_pkg::DVS_W'(trial - {1'b0, r_dvs})
                          : trial[fccw_pkg::DVS_W-1:0];
            r_quo <= {r_quo[fccw_pkg::DVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign o_rem_nz   = (r_rem != '0);

endmodule

`default_nettype wire

@@ src/fccw_dpath.sv @@
// Datapath: geometry registers, table store, cluster/lba arithmetic and the
// output register. Depends on fccw_pkg and fccw_div.
`timescale 1ns / 1ps
`default_nettype none

module fccw_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fccw_pkg::t_cmd                i_cmd,
    output fccw_pkg::t_status                  o_status,
    // configuration
    input  wire logic                          i_cfg_valid,
    input  wire logic [fccw_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [fccw_pkg::CFG_DW-1:0]   i_cfg_data,
    // input word
    input  wire logic                          i_req_type,
    input  wire logic [fccw_pkg::ADDR_W-1:0]   i_table_addr,
    input  wire logic [fccw_pkg::BYTE_W-1:0]   i_table_byte,
    input  wire logic [fccw_pkg::CLU_W-1:0]    i_start_cluster,
    // result word
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic [fccw_pkg::CLU_W-1:0]         o_cluster,
    output logic [fccw_pkg::LBA_W-1:0]         o_sector_lba,
    output logic                               o_last,
    output logic                               o_bad_start,
    output logic                               o_truncated
);

    // geometry
    logic [12:0] r_bps;
    logic [7:0]  r_spc;
    logic [15:0] r_rsv;
    logic [2:0]  r_fats;
    logic [15:0] r_spf;
    logic [15:0] r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bps  <= 13'd512;
            r_spc  <= 8'd1;
            r_rsv  <= 16'd1;
            r_fats <= 3'd2;
            r_spf  <= 16'd9;
            r_rec  <= 16'd224;
        end else if (i_cfg_valid) begin
            case (fccw_pkg::t_cfg_idx'(i_cfg_index))
                fccw_pkg::CFG_BYTES_PER_SECTOR:    r_bps  <= i_cfg_data[12:0];
                fccw_pkg::CFG_SECTORS_PER_CLUSTER: r_spc  <= i_cfg_data[7:0];
                fccw_pkg::CFG_RESERVED_SECTORS:    r_rsv  <= i_cfg_data;
                fccw_pkg::CFG_FAT_COUNT:           r_fats <= i_cfg_data[2:0];
                fccw_pkg::CFG_SECTORS_PER_FAT:     r_spf  <= i_cfg_data;
                fccw_pkg::CFG_ROOT_ENTRY_COUNT:    r_rec  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // root directory sectors = ceil(32 * entries / bytes_per_sector)
    logic                       div_done;
    logic [fccw_pkg::DVD_W-1:0] div_quo;
    logic                       div_rem_nz;

    fccw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.walk),
        .i_dividend ({r_rec, 5'b00000}),
        .i_divisor  (r_bps),
        .o_done     (div_done),
        .o_quotient (div_quo),
        .o_rem_nz   (div_rem_nz)
    );

    logic [19:0]                 r_base;
    logic [fccw_pkg::LBA_W-1:0]  r_root;
    logic [fccw_pkg::DVD_W:0]    root_secs;

    assign root_secs = (r_bps == '0) ? '0
                     : ({1'b0, div_quo} + (fccw_pkg::DVD_W+1)'(div_rem_nz));

    // table store
    logic [fccw_pkg::BYTE_W-1:0] r_mem [fccw_pkg::TABLE_BYTES];
    logic [fccw_pkg::BYTE_W-1:0] r_rdata;
    logic [fccw_pkg::BYTE_W-1:0] r_lo;
    logic [fccw_pkg::ADDR_W-1:0] idx;
    logic [fccw_pkg::ADDR_W-1:0] rd_addr;
    logic                        wr_ok;

    logic [fccw_pkg::CLU_W-1:0]  r_cur;
    logic [fccw_pkg::CLU_W-1:0]  r_nxt;
    logic                        r_end;
    logic                        r_bad;
    logic [fccw_pkg::CNT_W-1:0]  r_count;
    logic signed [21:0]          r_prod;
    logic [fccw_pkg::LBA_W-1:0]  r_lba;
    logic [15:0]                 word;
    logic [fccw_pkg::CLU_W-1:0]  nxt;
    logic                        at_limit;

    // entry of cluster c sits at byte c*3/2
    assign idx     = {1'b0, r_cur} + fccw_pkg::ADDR_W'(r_cur >> 1);
    assign rd_addr = i_cmd.rd_hi ? (idx + fccw_pkg::ADDR_W'(1)) : idx;
    assign wr_ok   = ({1'b0, i_table_addr} < (fccw_pkg::ADDR_W+1)'(fccw_pkg::TABLE_BYTES));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            r_mem[i_table_addr[fccw_pkg::TABLE_AW-1:0]] <= i_table_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_lo || i_cmd.rd_hi) begin
            r_rdata <= r_mem[rd_addr[fccw_pkg::TABLE_AW-1:0]];
        end
    end

    assign word     = {r_rdata, r_lo};
    assign nxt      = r_cur[0] ? word[15:4] : word[11:0];
    assign at_limit = (r_count == fccw_pkg::CNT_W'(fccw_pkg::MAX_CHAIN - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            r_cur   <= i_start_cluster;
            r_count <= '0;
            r_bad   <= (i_start_cluster < fccw_pkg::CLU_W'(2));
            r_lba   <= '0;
            r_base  <= 20'(r_rsv) + 20'(r_spf) * 20'(r_fats);
        end
        if (i_cmd.root_load) begin
            r_root <= fccw_pkg::LBA_W'(r_base) + fccw_pkg::LBA_W'(root_secs);
        end
        if (i_cmd.rd_lo) begin
            // (cluster - 2) * sectors_per_cluster, signed so wrap is mod 2^32
            r_prod <= 22'($signed({1'b0, r_cur} - 13'd2)) * 22'($signed({1'b0, r_spc}));
        end
        if (i_cmd.rd_hi) begin
            r_lo  <= r_rdata;
            r_lba <= r_root + fccw_pkg::LBA_W'(r_prod);
        end
        if (i_cmd.nxt_load) begin
            r_nxt <= nxt;
            r_end <= (nxt >= fccw_pkg::END_MARK);
        end
        if (i_cmd.step) begin
            r_cur   <= r_nxt;
            r_count <= r_count + fccw_pkg::CNT_W'(1);
        end
    end

    // output register
    logic r_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_cluster    <= r_cur;
            o_sector_lba <= r_lba;
            o_last       <= o_status.last;
            o_bad_start  <= r_bad;
            o_truncated  <= !r_bad && !r_end && at_limit;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status.req_walk  = i_req_type;
    assign o_status.start_bad = (i_start_cluster < fccw_pkg::CLU_W'(2));
    assign o_status.div_done  = div_done;
    assign o_status.out_free  = out_free;
    assign o_status.last      = r_bad || r_end || at_limit;

endmodule

`default_nettype wire

@@ src/fccw_ctrl.sv @@
// Controller: sequences loads, the root divide and the per-cluster table
// reads and result words. Depends on fccw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fccw_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire fccw_pkg::t_status i_status,
    output fccw_pkg::t_cmd         o_cmd,
    output logic                   o_busy
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_RD_LO = 6'b000100,
        S_RD_HI = 6'b001000,
        S_NEXT  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.req_walk) begin
                        o_cmd.walk = 1'b1;
                        n_state    = i_status.start_bad ? S_EMIT : S_DIV;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.root_load = 1'b1;
                    n_state         = S_RD_LO;
                end
            end
            S_RD_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = S_RD_HI;
            end
            S_RD_HI: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.nxt_load = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_RD_LO;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire
